FILE: rtl/pixel_delta_prefix_code_packer_core_defines.svh
`ifndef PIXEL_DELTA_PREFIX_CODE_PACKER_CORE_DEFINES_SVH
`define PIXEL_DELTA_PREFIX_CODE_PACKER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PDPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define PDPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pdpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdpc_pkg;

    localparam int PIX_W     = 8;
    localparam int VALID_W   = 4;
    localparam int TOTAL_W   = 24;
    localparam int CODE_W    = 12;   // longest code: 3 prefix + 8 magnitude + 1 sign
    localparam int LEN_W     = 4;
    localparam int BYTE_W    = 8;
    localparam int ACC_W     = BYTE_W + CODE_W;
    localparam int ACC_CNT_W = 5;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [TOTAL_W-1:0] TOTAL_CAP = {TOTAL_W{1'b1}};

    // Class boundaries of the magnitude code.
    localparam logic [PIX_W-1:0] CLASS1_MIN = 8'd2;
    localparam logic [PIX_W-1:0] CLASS2_MIN = 8'd6;
    localparam logic [PIX_W-1:0] CLASS3_MIN = 8'd22;

    localparam logic [1:0] PFX_CLASS1 = 2'b10;
    localparam logic [2:0] PFX_CLASS2 = 3'b110;
    localparam logic [2:0] PFX_CLASS3 = 3'b111;

    localparam logic [LEN_W-1:0] LEN_CLASS0 = 4'd3;
    localparam logic [LEN_W-1:0] LEN_CLASS1 = 4'd5;
    localparam logic [LEN_W-1:0] LEN_CLASS2 = 4'd8;
    localparam logic [LEN_W-1:0] LEN_CLASS3 = 4'd12;

    // One classified request between the front and the packer.
    typedef struct packed {
        logic                 raw;
        logic                 last;
        logic [CODE_W-1:0]    data;   // code left-aligned, or raw pixel in the top byte
        logic [LEN_W-1:0]     len;
        logic [TOTAL_W-1:0]   total;
        logic [PIX_W-1:0]     maxd;
    } t_entry;

    typedef struct packed {
        logic [ACC_CNT_W-1:0] n;
        logic                 close;
    } t_back_stat;

endpackage

`default_nettype wire

FILE: rtl/pdpc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pdpc_pix_if;
    import pdpc_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             first_pixel;
    logic             last_pixel;

    modport source (output valid, output pixel, output first_pixel, output last_pixel,
                    input ready);
    modport sink   (input valid, input pixel, input first_pixel, input last_pixel,
                    output ready);
endinterface

interface pdpc_code_if;
    import pdpc_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   out_byte;
    logic [VALID_W-1:0] bits_valid;
    logic               is_raw_pixel;
    logic               is_last;
    logic [TOTAL_W-1:0] image_bit_count;
    logic [PIX_W-1:0]   max_abs_diff;

    modport source (output valid, output out_byte, output bits_valid, output is_raw_pixel,
                    output is_last, output image_bit_count, output max_abs_diff,
                    input ready);
    modport sink   (input valid, input out_byte, input bits_valid, input is_raw_pixel,
                    input is_last, input image_bit_count, input max_abs_diff,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/pdpc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pdpc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pdpc_pix_if.sink         i_pix,
    input  logic             i_q_full,
    output logic             o_push,
    output pdpc_pkg::t_entry o_entry
);
    import pdpc_pkg::*;

    logic [PIX_W-1:0]   r_prev, n_prev;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [PIX_W-1:0]   r_max, n_max;

    logic               sign;
    logic [PIX_W-1:0]   mag;
    logic [PIX_W-1:0]   mag_m2, mag_m6, mag_m22;
    logic [CODE_W-1:0]  code;
    logic [LEN_W-1:0]   len;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] upd_total;
    logic [PIX_W-1:0]   upd_max;
    logic               accept;

    assign i_pix.ready = !i_q_full;
    assign accept      = i_pix.valid && !i_q_full;

    always_comb begin
        sign    = i_pix.pixel < r_prev;
        mag     = sign ? (r_prev - i_pix.pixel) : (i_pix.pixel - r_prev);
        mag_m2  = mag - CLASS1_MIN;
        mag_m6  = mag - CLASS2_MIN;
        mag_m22 = mag - CLASS3_MIN;

        if (mag < CLASS1_MIN) begin
            code = {1'b0, mag[0], sign, 9'b0};
            len  = LEN_CLASS0;
        end else if (mag < CLASS2_MIN) begin
            code = {PFX_CLASS1, mag_m2[1:0], sign, 7'b0};
            len  = LEN_CLASS1;
        end else if (mag < CLASS3_MIN) begin
            code = {PFX_CLASS2, mag_m6[3:0], sign, 4'b0};
            len  = LEN_CLASS2;
        end else begin
            code = {PFX_CLASS3, mag_m22, sign};
            len  = LEN_CLASS3;
        end

        sum       = {1'b0, r_total} + (TOTAL_W + 1)'(len);
        upd_total = (sum > {1'b0, TOTAL_CAP}) ? TOTAL_CAP : sum[TOTAL_W-1:0];
        upd_max   = (mag > r_max) ? mag : r_max;

        o_push = accept;
        if (i_pix.first_pixel) begin
            o_entry.raw   = 1'b1;
            o_entry.data  = {i_pix.pixel, {(CODE_W - PIX_W){1'b0}}};
            o_entry.len   = '0;
            o_entry.total = '0;
            o_entry.maxd  = '0;
        end else begin
            o_entry.raw   = 1'b0;
            o_entry.data  = code;
            o_entry.len   = len;
            o_entry.total = upd_total;
            o_entry.maxd  = upd_max;
        end
        o_entry.last = i_pix.last_pixel;

        n_prev  = r_prev;
        n_total = r_total;
        n_max   = r_max;
        if (accept) begin
            n_prev = i_pix.pixel;
            // A first pixel or the end of an image restarts the counters.
            if (i_pix.first_pixel || i_pix.last_pixel) begin
                n_total = '0;
                n_max   = '0;
            end else begin
                n_total = upd_total;
                n_max   = upd_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_total <= '0;
            r_max   <= '0;
        end else begin
            r_prev  <= n_prev;
            r_total <= n_total;
            r_max   <= n_max;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pdpc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pdpc_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  pdpc_pkg::t_entry                i_entry,
    input  logic                            i_pop,
    output logic                            o_valid,
    output logic                            o_full,
    output pdpc_pkg::t_entry                o_head,
    output logic [pdpc_pkg::QCNT_W-1:0]     o_count
);
    import pdpc_pkg::*;

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, n_wr;
    logic [QPTR_W-1:0]   r_rd, n_rd;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;
    logic                do_pop;

    assign o_valid = r_cnt != '0;
    assign o_full  = r_cnt == QCNT_W'(QDEPTH);
    assign o_head  = r_mem[r_rd];
    assign o_count = r_cnt;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + QCNT_W'(i_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pdpc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pdpc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  pdpc_pkg::t_entry     i_q_head,
    output logic                 o_pop,
    output pdpc_pkg::t_back_stat o_stat,
    pdpc_code_if.source          o_code
);
    import pdpc_pkg::*;

    // Bit accumulator: the top r_n bits of r_w are pending code bits, the rest zero.
    logic [ACC_W-1:0]     r_w, n_w;
    logic [ACC_CNT_W-1:0] r_n, n_n;
    logic                 r_close, n_close;
    logic [TOTAL_W-1:0]   r_total, n_total;
    logic [PIX_W-1:0]     r_max, n_max;

    logic                 r_ov, n_ov;
    logic [PIX_W-1:0]     r_byte, n_byte;
    logic [VALID_W-1:0]   r_bits, n_bits;
    logic                 r_raw, n_raw;
    logic                 r_last, n_last;
    logic [TOTAL_W-1:0]   r_otot, n_otot;
    logic [PIX_W-1:0]     r_omax, n_omax;

    logic                 out_free;
    logic                 have_byte;
    logic                 emit_full, emit_close;
    logic                 can_take, take_coded, take_raw;
    logic                 load;
    logic [ACC_W-1:0]     w1, shifted;
    logic [ACC_CNT_W-1:0] n1;

    always_comb begin
        out_free   = !r_ov || o_code.ready;
        have_byte  = r_n >= ACC_CNT_W'(BYTE_W);
        emit_full  = have_byte && out_free;
        emit_close = !have_byte && r_close && out_free;

        w1 = emit_full ? (r_w << BYTE_W) : r_w;
        n1 = emit_full ? (r_n - ACC_CNT_W'(BYTE_W)) : r_n;

        can_take   = i_q_valid && !r_close && (n1 < ACC_CNT_W'(BYTE_W));
        take_coded = can_take && !i_q_head.raw;
        // A raw pixel needs the output register to itself.
        take_raw   = can_take && i_q_head.raw && out_free && !emit_full;
        o_pop      = take_coded || take_raw;

        shifted = {i_q_head.data, {BYTE_W{1'b0}}} >> n1[2:0];

        n_w     = w1;
        n_n     = n1;
        n_close = r_close;
        n_total = r_total;
        n_max   = r_max;
        if (emit_close || take_raw) begin
            n_w     = '0;
            n_n     = '0;
            n_close = 1'b0;
        end
        if (take_coded) begin
            n_w     = {w1[ACC_W-1 -: BYTE_W], {CODE_W{1'b0}}} | shifted;
            n_n     = n1 + ACC_CNT_W'(i_q_head.len);
            n_close = i_q_head.last;
            n_total = i_q_head.total;
            n_max   = i_q_head.maxd;
        end

        load   = emit_full || emit_close || take_raw;
        n_ov   = load ? 1'b1 : (o_code.ready ? 1'b0 : r_ov);
        n_byte = r_byte;
        n_bits = r_bits;
        n_raw  = r_raw;
        n_last = r_last;
        n_otot = r_otot;
        n_omax = r_omax;
        if (emit_full) begin
            n_byte = r_w[ACC_W-1 -: BYTE_W];
            n_bits = VALID_W'(BYTE_W);
            n_raw  = 1'b0;
            n_last = 1'b0;
            n_otot = '0;
            n_omax = '0;
        end else if (emit_close) begin
            n_byte = r_w[ACC_W-1 -: BYTE_W];
            n_bits = r_n[VALID_W-1:0];
            n_raw  = 1'b0;
            n_last = 1'b1;
            n_otot = r_total;
            n_omax = r_max;
        end else if (take_raw) begin
            n_byte = i_q_head.data[CODE_W-1 -: PIX_W];
            n_bits = VALID_W'(BYTE_W);
            n_raw  = 1'b1;
            n_last = i_q_head.last;
            n_otot = '0;
            n_omax = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w     <= '0;
            r_n     <= '0;
            r_close <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_w     <= n_w;
            r_n     <= n_n;
            r_close <= n_close;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        r_max   <= n_max;
        r_byte  <= n_byte;
        r_bits  <= n_bits;
        r_raw   <= n_raw;
        r_last  <= n_last;
        r_otot  <= n_otot;
        r_omax  <= n_omax;
    end

    assign o_stat.n     = r_n;
    assign o_stat.close = r_close;

    assign o_code.valid           = r_ov;
    assign o_code.out_byte        = r_byte;
    assign o_code.bits_valid      = r_bits;
    assign o_code.is_raw_pixel    = r_raw;
    assign o_code.is_last         = r_last;
    assign o_code.image_bit_count = r_otot;
    assign o_code.max_abs_diff    = r_omax;

endmodule

`default_nettype wire

FILE: rtl/pixel_delta_prefix_code_packer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Payload                                        Request when
// i_pix     in         pixel, first_pixel, last_pixel                 valid && ready
// o_code    out        out_byte, bits_valid, is_raw_pixel, is_last,   valid && ready
//                      image_bit_count, max_abs_diff
//
// A pixel request is taken every cycle while the two-entry queue has room.
// The packer puts out one byte per cycle from its single output register while
// the receiver takes them; a 12-bit code can complete two bytes, and a closing
// result follows at the end of an image that ends on a coded pixel.
// A raw pixel goes from the queue straight into the output register, while a code
// byte or a closing result passes through the bit accumulator on the way.
// Reset is synchronous and active low.
// A stalled output holds its result; the queue keeps accepting until full.

module pixel_delta_prefix_code_packer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pdpc_pix_if.sink    i_pix,
    pdpc_code_if.source o_code
);
    import pdpc_pkg::*;

    `include "pixel_delta_prefix_code_packer_core_defines.svh"

    logic              push;
    t_entry            push_entry;
    logic              q_full;
    logic              q_valid;
    t_entry            q_head;
    logic              pop;
    logic [QCNT_W-1:0] q_count;
    t_back_stat        back_stat;

    pdpc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (i_pix),
        .i_q_full (q_full),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    pdpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_head  (q_head),
        .o_count (q_count)
    );

    pdpc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_pop     (pop),
        .o_stat    (back_stat),
        .o_code    (o_code)
    );

    // An accepted request is always waiting in the queue in the following cycle.
    `PDPC_ASSERT_NEXT(a_push_lands, i_pix.valid && i_pix.ready, q_count != '0, "request lost")

    // A full byte in the accumulator goes out as soon as the output register is free.
    `PDPC_ASSERT_NEXT(a_byte_drains,
        back_stat.n >= ACC_CNT_W'(BYTE_W) && (!o_code.valid || o_code.ready),
        o_code.valid, "pending byte not emitted")

    // The closing result of a coded image carries a partial byte only.
    `PDPC_ASSERT_NOW(a_close_partial,
        o_code.valid && o_code.is_last && !o_code.is_raw_pixel,
        o_code.bits_valid < VALID_W'(BYTE_W), "closing result holds a full byte")

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import pdpc_pkg::*;

    localparam int NUM_DIRECTED = 21;
    localparam int NUM_RANDOM   = 340;
    localparam int IDLE_LIMIT   = 1000;
    localparam int TAIL_CYCLES  = 10;

    typedef struct packed {
        logic [PIX_W-1:0]   out_byte;
        logic [VALID_W-1:0] bits_valid;
        logic               is_raw_pixel;
        logic               is_last;
        logic [TOTAL_W-1:0] image_bit_count;
        logic [PIX_W-1:0]   max_abs_diff;
    } t_code_res;

    // Up to two expected results can be typed into a directed row; typed[0] comes first.
    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic              first;
        logic              last;
        logic [1:0]        n_typed;
        t_code_res [1:0]   typed;
    } t_stim_row;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_BURSTY
    } t_sink_mode;

    localparam t_code_res NO_RES = '0;

    logic i_clk;
    logic i_rst_n;

    pdpc_pix_if  pix_if ();
    pdpc_code_if code_if ();

    pixel_delta_prefix_code_packer_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_code  (code_if)
    );

    // Predicted state of the coder.
    logic [PIX_W-1:0]   last_pix;
    logic [7:0]         pack_byte;
    int                 free_bits;
    logic [TOTAL_W-1:0] coded_bits;
    logic [PIX_W-1:0]   peak_diff;

    t_code_res fresh_res [3];
    int        fresh_cnt;
    t_code_res expected_codes [$];

    int err_cnt;
    int items_sent;
    int burst_left;
    int idle_cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_code_res mk_res(input logic [7:0] out_byte, input int bits_valid,
                                         input bit raw, input bit last, input int total,
                                         input int maxd);
        t_code_res r;
        r.out_byte        = out_byte;
        r.bits_valid      = bits_valid[VALID_W-1:0];
        r.is_raw_pixel    = raw;
        r.is_last         = last;
        r.image_bit_count = total[TOTAL_W-1:0];
        r.max_abs_diff    = maxd[PIX_W-1:0];
        return r;
    endfunction

    function automatic t_stim_row row(input logic [7:0] pix, input bit first, input bit last,
                                      input int n_typed, input t_code_res r1,
                                      input t_code_res r0);
        t_stim_row s;
        s.pixel   = pix;
        s.first   = first;
        s.last    = last;
        s.n_typed = n_typed[1:0];
        s.typed   = {r1, r0};
        return s;
    endfunction

    task automatic clear_image();
        pack_byte  = '0;
        free_bits  = 8;
        coded_bits = '0;
        peak_diff  = '0;
    endtask

    task automatic add_fresh(input t_code_res r);
        fresh_res[fresh_cnt] = r;
        fresh_cnt++;
    endtask

    // Packs the code MSB first; a byte is emitted as soon as it fills.
    task automatic shift_bits(input logic [11:0] code, input int len);
        int         i;
        logic [24:0] sum;
        for (i = len - 1; i >= 0; i--) begin
            pack_byte[free_bits-1] = code[i];
            free_bits--;
            if (free_bits == 0) begin
                add_fresh(mk_res(pack_byte, 8, 1'b0, 1'b0, 0, 0));
                pack_byte = '0;
                free_bits = 8;
            end
        end
        sum = {1'b0, coded_bits} + 25'(len);
        coded_bits = sum[24] ? TOTAL_CAP : sum[TOTAL_W-1:0];
    endtask

    task automatic code_pixel(input logic [7:0] pix, input bit first, input bit last);
        logic [7:0]  mag;
        logic [7:0]  rem;
        bit          neg;
        logic [11:0] code;
        int          len;
        fresh_cnt = 0;
        if (first) begin
            clear_image();
            last_pix = pix;
            add_fresh(mk_res(pix, 8, 1'b1, last, 0, 0));
        end else begin
            neg      = pix < last_pix;
            mag      = neg ? last_pix - pix : pix - last_pix;
            last_pix = pix;
            if (mag > peak_diff)
                peak_diff = mag;
            if (mag < 8'd2) begin
                code = {10'd0, 1'b0, mag[0]};
                len  = 2;
            end else if (mag < 8'd6) begin
                rem  = mag - 8'd2;
                code = {8'd0, 2'b10, rem[1:0]};
                len  = 4;
            end else if (mag < 8'd22) begin
                rem  = mag - 8'd6;
                code = {5'd0, 3'b110, rem[3:0]};
                len  = 7;
            end else begin
                rem  = mag - 8'd22;
                code = {1'b0, 3'b111, rem};
                len  = 11;
            end
            code = {code[10:0], neg};
            shift_bits(code, len + 1);
            if (last) begin
                if (free_bits < 8)
                    add_fresh(mk_res(pack_byte, 8 - free_bits, 1'b0, 1'b1,
                                     int'(coded_bits), int'(peak_diff)));
                else
                    add_fresh(mk_res(8'h00, 0, 1'b0, 1'b1, int'(coded_bits),
                                     int'(peak_diff)));
                clear_image();
            end
        end
    endtask

    task automatic send_item(input logic [7:0] pix, input bit first, input bit last,
                             input int n_typed, input t_code_res [1:0] typed);
        int gap;
        int i;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            pix_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        @(negedge i_clk);
        pix_if.valid       <= 1'b1;
        pix_if.pixel       <= pix;
        pix_if.first_pixel <= first;
        pix_if.last_pixel  <= last;
        do
            @(posedge i_clk);
        while (!pix_if.ready);
        code_pixel(pix, first, last);
        if (n_typed > 0) begin
            for (i = 0; i < n_typed; i++)
                expected_codes.push_back(typed[i]);
        end else begin
            for (i = 0; i < fresh_cnt; i++)
                expected_codes.push_back(fresh_res[i]);
        end
        items_sent++;
        burst_left--;
    endtask

    task automatic drain_codes();
        @(negedge i_clk);
        pix_if.valid <= 1'b0;
        burst_left = 0;
        while (expected_codes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Receiver: the stall pattern switches between a few modes of random length.
    initial begin
        t_sink_mode mode;
        int         mode_left;
        mode          = SINK_OPEN;
        mode_left     = 0;
        code_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            case (mode)
                SINK_OPEN:   code_if.ready <= 1'b1;
                SINK_COIN:   code_if.ready <= 1'($urandom_range(0, 1));
                SINK_SPARSE: code_if.ready <= ($urandom_range(0, 3) == 0);
                default:     code_if.ready <= ((mode_left % 16) < 5);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_code_res want;
        if (i_rst_n && code_if.valid && code_if.ready) begin
            if (expected_codes.size() == 0) begin
                $error("unexpected result: out_byte %0h bits_valid %0d is_last %0b",
                       code_if.out_byte, code_if.bits_valid, code_if.is_last);
                err_cnt++;
            end else begin
                want = expected_codes.pop_front();
                check_field("out_byte", 32'(want.out_byte), 32'(code_if.out_byte));
                check_field("bits_valid", 32'(want.bits_valid), 32'(code_if.bits_valid));
                check_field("is_raw_pixel", 32'(want.is_raw_pixel),
                            32'(code_if.is_raw_pixel));
                check_field("is_last", 32'(want.is_last), 32'(code_if.is_last));
                check_field("image_bit_count", 32'(want.image_bit_count),
                            32'(code_if.image_bit_count));
                check_field("max_abs_diff", 32'(want.max_abs_diff),
                            32'(code_if.max_abs_diff));
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_if.valid && pix_if.ready) || (code_if.valid && code_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_stim_row dir_rows [NUM_DIRECTED];
        int        k;
        int        len;
        int        p;
        int        m;
        bit        pressure_done;

        i_rst_n            = 1'b0;
        pix_if.valid       = 1'b0;
        pix_if.pixel       = '0;
        pix_if.first_pixel = 1'b0;
        pix_if.last_pixel  = 1'b0;
        err_cnt            = 0;
        items_sent         = 0;
        burst_left         = 0;
        idle_cycles        = 0;
        pressure_done      = 1'b0;
        last_pix           = '0;
        clear_image();

        dir_rows = '{
            // Pixel without a first pixel right after reset: zero difference, three bits.
            row(8'h00, 1'b0, 1'b1, 1, NO_RES, mk_res(8'h00, 3, 1'b0, 1'b1, 3, 0)),
            // First and last together.
            row(8'hA5, 1'b1, 1'b1, 1, NO_RES, mk_res(8'hA5, 8, 1'b1, 1'b1, 0, 0)),
            row(8'h00, 1'b1, 1'b0, 1, NO_RES, mk_res(8'h00, 8, 1'b1, 1'b0, 0, 0)),
            // Largest positive step: twelve bits, one full byte and a four-bit flush.
            row(8'hFF, 1'b0, 1'b1, 2, mk_res(8'h20, 4, 1'b0, 1'b1, 12, 255),
                mk_res(8'hFD, 8, 1'b0, 1'b0, 0, 0)),
            row(8'hFF, 1'b1, 1'b0, 1, NO_RES, mk_res(8'hFF, 8, 1'b1, 1'b0, 0, 0)),
            row(8'h00, 1'b0, 1'b0, 0, NO_RES, NO_RES),
            row(8'h64, 1'b1, 1'b0, 1, NO_RES, mk_res(8'h64, 8, 1'b1, 1'b0, 0, 0)),
            // Class boundaries in both directions.
            row(8'h64, 1'b0, 1'b0, 0, NO_RES, NO_RES),
            row(8'h65, 1'b0, 1'b0, 0, NO_RES, NO_RES),
            row(8'h63, 1'b0, 1'b0, 0, NO_RES, NO_RES),
            row(8'h68, 1'b0, 1'b0, 0, NO_RES, NO_RES),
            row(8'h62, 1'b0, 1'b0, 0, NO_RES, NO_RES),
            row(8'h77, 1'b0, 1'b0, 0, NO_RES, NO_RES),
            row(8'h61, 1'b0, 1'b0, 0, NO_RES, NO_RES),
            row(8'h63, 1'b0, 1'b0, 0, NO_RES, NO_RES),
            // A first pixel in the middle of an image drops the pending bits.
            row(8'h5A, 1'b1, 1'b0, 1, NO_RES, mk_res(8'h5A, 8, 1'b1, 1'b0, 0, 0)),
            row(8'h5A, 1'b0, 1'b1, 1, NO_RES, mk_res(8'h00, 3, 1'b0, 1'b1, 3, 0)),
            // Pixels after a last pixel with no first pixel continue from the old value.
            row(8'hC3, 1'b0, 1'b0, 0, NO_RES, NO_RES),
            row(8'h3C, 1'b0, 1'b1, 0, NO_RES, NO_RES),
            row(8'h00, 1'b1, 1'b1, 1, NO_RES, mk_res(8'h00, 8, 1'b1, 1'b1, 0, 0)),
            row(8'hFF, 1'b1, 1'b1, 1, NO_RES, mk_res(8'hFF, 8, 1'b1, 1'b1, 0, 0))
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < NUM_DIRECTED; k++)
            send_item(dir_rows[k].pixel, dir_rows[k].first, dir_rows[k].last,
                      dir_rows[k].n_typed, dir_rows[k].typed);
        drain_codes();

        while (items_sent < NUM_DIRECTED + NUM_RANDOM) begin
            if (!pressure_done && items_sent >= NUM_DIRECTED + NUM_RANDOM / 2) begin
                drain_codes();
                pressure_done = 1'b1;
            end
            if ($urandom_range(0, 99) < 85) begin
                // Well-formed image whose steps are spread over the four code classes.
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                  : $urandom_range(1, 12);
                p = $urandom_range(0, 255);
                for (k = 0; k < len; k++) begin
                    if (k > 0) begin
                        case ($urandom_range(0, 3))
                            0:       m = $urandom_range(0, 1);
                            1:       m = $urandom_range(2, 5);
                            2:       m = $urandom_range(6, 21);
                            default: m = $urandom_range(22, 255);
                        endcase
                        if ($urandom_range(0, 1) == 1 && p >= m)
                            p = p - m;
                        else if (p + m <= 255)
                            p = p + m;
                        else if (p >= m)
                            p = p - m;
                        else
                            p = $urandom_range(0, 255);
                    end
                    send_item(p[7:0], k == 0, k == len - 1, 0, '0);
                end
            end else begin
                send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 0, '0);
            end
        end

        @(negedge i_clk);
        pix_if.valid <= 1'b0;
        while (expected_codes.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0 && expected_codes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: pixel_delta_prefix_code_packer_core.f
+incdir+rtl
rtl/pdpc_pkg.sv
rtl/pdpc_if.sv
rtl/pdpc_front.sv
rtl/pdpc_queue.sv
rtl/pdpc_back.sv
rtl/pixel_delta_prefix_code_packer_core.sv
dv/tb.sv
